// ----- hw/rtl/lux_pkg.sv -----
// Shared widths, types, coefficient tables and register codes for the lux core.
// No dependencies; compile first.
package lux_pkg;

  localparam int CNT_W      = 16;   // raw channel count
  localparam int SCALE_W    = 19;   // channel scale incl. the 1x-gain shift
  localparam int PROD_W     = CNT_W + SCALE_W;
  localparam int SCALE_SH   = 10;   // scale has 10 fractional bits
  localparam int CH_W       = PROD_W - SCALE_SH;  // scaled channel value
  localparam int RATIO_FRAC = 9;
  localparam int REM_W      = CH_W + RATIO_FRAC + 1;  // dividend c1 << 10
  localparam int DIV_Q_BITS = 12;   // quotient bits kept before saturating
  localparam int DIV_STEPS  = 2;    // restoring steps per divider stage
  localparam int DIV_STAGES = DIV_Q_BITS / DIV_STEPS;
  localparam int DCMP_W     = REM_W + 2;  // compare width for c0 << 11
  localparam int COEF_W     = 10;
  localparam int SEGMENTS   = 8;
  localparam int SEG_W      = $clog2(SEGMENTS);
  localparam int LUX_SH     = 14;
  localparam int LUX_W      = 20;

  localparam logic [14:0] TSCALE_SHORT = 15'h7517;
  localparam logic [14:0] TSCALE_MID   = 15'h0FE7;
  localparam logic [14:0] TSCALE_UNIT  = 15'h0400;

  // Configuration register indexes
  localparam logic [1:0] REG_HIGH_GAIN = 2'd0;
  localparam logic [1:0] REG_INTEG_SEL = 2'd1;
  localparam logic [1:0] REG_PKG_TYPE  = 2'd2;

  // Integration time codes
  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;

  typedef logic [CNT_W-1:0]      count_t;
  typedef logic [SCALE_W-1:0]    scale_t;
  typedef logic [PROD_W-1:0]     prod_t;
  typedef logic [CH_W-1:0]       chan_t;
  typedef logic [REM_W-1:0]      rem_t;
  typedef logic [DIV_Q_BITS-1:0] quo_t;
  typedef logic [COEF_W-1:0]     coef_t;
  typedef logic [SEG_W-1:0]      seg_t;
  typedef logic [LUX_W-1:0]      lux_t;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
    rem_t  rem;
    quo_t  q;
    logic  sat;    // ratio far past the last breakpoint
    logic  zero;   // broadband zero after scaling
  } div_stage_t;

  // Piecewise-linear tables, row 0 = T package, row 1 = CS package
  localparam coef_t BRK_TAB [2][SEGMENTS] = '{
    '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a, 10'h29a},
    '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a, 10'h29a}
  };
  localparam coef_t OFS_TAB [2][SEGMENTS] = '{
    '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
  };
  localparam coef_t SLP_TAB [2][SEGMENTS] = '{
    '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
    '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
  };

endpackage

// ----- hw/rtl/lux_in_if.sv -----
// Input channel: one pair of raw counts with valid/ready.
// Depends on lux_pkg.
interface lux_in_if import lux_pkg::*; ();
  logic   valid;
  logic   ready;
  count_t broadband_count;
  count_t infrared_count;

  modport source (output valid, output broadband_count, output infrared_count, input ready);
  modport sink   (input valid, input broadband_count, input infrared_count, output ready);
endinterface

// ----- hw/rtl/lux_out_if.sv -----
// Result channel: one lux value with valid/ready.
// Depends on lux_pkg.
interface lux_out_if import lux_pkg::*; ();
  logic valid;
  logic ready;
  lux_t lux;

  modport source (output valid, output lux, input ready);
  modport sink   (input valid, input lux, output ready);
endinterface

// ----- hw/rtl/two_channel_lux_calculation_core.sv -----
// Two-channel lux calculation core: scale, ratio divide, segment lookup, lux.
// Depends on lux_pkg, lux_in_if and lux_out_if.
//
//   channel | dir | handshake    | payload
//   --------+-----+--------------+-------------------------------------
//   in_ch   | in  | valid/ready  | broadband_count[15:0], infrared_count[15:0]
//   out_ch  | out | valid/ready  | lux[19:0]
//   cfg_*   | in  | cfg_we only  | cfg_index[1:0], cfg_wdata[1:0]
//
// Throughput is one transaction per cycle unless out_ch stalls. The path is
// eleven register stages: count scaling, fraction drop, the six-stage
// restoring ratio divider (two quotient bits per stage), segment lookup,
// coefficient products and the output round.
// Reset (rst_n low, synchronous) clears all stage valid bits and the config
// registers. Each stage holds while its successor is full and stalled, so
// bubbles collapse and in_ch.ready drops only when every stage is occupied.
module two_channel_lux_calculation_core
  import lux_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lux_in_if.sink     in_ch,
  lux_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [1:0] cfg_wdata
);

  // Stage map
  localparam int ST_MUL0  = 0;                      // count * scale
  localparam int ST_SCALE = 1;                      // drop fraction, set up divide
  localparam int ST_DIV0  = ST_SCALE + 1;           // first divider stage
  localparam int ST_SEG   = ST_DIV0 + DIV_STAGES;   // round ratio, pick segment
  localparam int ST_MUL   = ST_SEG + 1;             // coefficient products
  localparam int ST_OUT   = ST_MUL + 1;             // difference, round, clamp
  localparam int NSTG     = ST_OUT + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic       high_gain_r;
  logic [1:0] integ_sel_r;
  logic       pkg_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_gain_r <= 1'b0;
      integ_sel_r <= INTEG_13MS;
      pkg_type_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_GAIN: high_gain_r <= cfg_wdata[0];
        REG_INTEG_SEL: integ_sel_r <= cfg_wdata;
        REG_PKG_TYPE:  pkg_type_r  <= cfg_wdata[0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage advances when it is empty or its successor advances
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[ST_OUT] = !vld_r[ST_OUT] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ch.ready = adv[ST_MUL0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[ST_MUL0]) begin
        vld_r[ST_MUL0] <= in_ch.valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: scale both counts
  // ---------------------------------------------------------------------------
  scale_t scale;
  prod_t  prod0_r, prod1_r;

  always_comb begin
    scale = '0;
    case (integ_sel_r)
      INTEG_13MS:  scale = SCALE_W'(TSCALE_SHORT);
      INTEG_101MS: scale = SCALE_W'(TSCALE_MID);
      default:     scale = SCALE_W'(TSCALE_UNIT);  // nominal time, no scaling
    endcase
    if (!high_gain_r) begin
      scale = scale << 4;  // 1x gain
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_MUL0]) begin
      prod0_r <= PROD_W'(in_ch.broadband_count) * PROD_W'(scale);
      prod1_r <= PROD_W'(in_ch.infrared_count) * PROD_W'(scale);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: drop the scale fraction and prepare the ratio divide.
  // A quotient of 4096 or more (c1 >= 4*c0) lies past every breakpoint, so
  // flag it and keep only twelve quotient bits.
  // ---------------------------------------------------------------------------
  div_stage_t div_r [DIV_STAGES+1];
  chan_t      c0_w, c1_w;

  assign c0_w = prod0_r[PROD_W-1:SCALE_SH];
  assign c1_w = prod1_r[PROD_W-1:SCALE_SH];

  always_ff @(posedge clk) begin
    if (adv[ST_SCALE]) begin
      div_r[0].c0   <= c0_w;
      div_r[0].c1   <= c1_w;
      div_r[0].rem  <= {c1_w, (RATIO_FRAC + 1)'(0)};
      div_r[0].q    <= '0;
      div_r[0].sat  <= {2'b00, c1_w} >= {c0_w, 2'b00};
      div_r[0].zero <= (c0_w == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider stages: restoring division, two quotient bits per stage, MSB first
  // ---------------------------------------------------------------------------
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    localparam int KHI = DIV_Q_BITS - 1 - (j - 1) * DIV_STEPS;
    div_stage_t nxt;

    always_comb begin
      logic [DCMP_W-1:0] dsh;
      logic [DCMP_W-1:0] rext;
      nxt = div_r[j-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        dsh  = DCMP_W'(nxt.c0) << (KHI - s);
        rext = DCMP_W'(nxt.rem);
        if (rext >= dsh) begin
          nxt.rem          = REM_W'(rext - dsh);
          nxt.q[KHI - s]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[ST_SCALE + j]) begin
        div_r[j] <= nxt;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Segment stage: round the ratio, pick slope and offset
  // ---------------------------------------------------------------------------
  div_stage_t             dq;
  logic [DIV_Q_BITS:0]    ratio_sum;
  quo_t                   ratio;
  seg_t                   seg;
  chan_t                  c0_seg_r, c1_seg_r;
  coef_t                  ofs_r, slp_r;

  assign dq        = div_r[DIV_STAGES];
  assign ratio_sum = {1'b0, dq.q} + (DIV_Q_BITS + 1)'(1);

  always_comb begin
    if (dq.zero) begin
      ratio = '0;
    end else if (dq.sat) begin
      ratio = '1;
    end else begin
      ratio = ratio_sum[DIV_Q_BITS:1];
    end
    seg = SEG_W'(SEGMENTS - 1);
    for (int i = SEGMENTS - 1; i >= 0; i--) begin
      if (ratio <= DIV_Q_BITS'(BRK_TAB[pkg_type_r][i])) begin
        seg = SEG_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SEG]) begin
      c0_seg_r <= dq.c0;
      c1_seg_r <= dq.c1;
      ofs_r    <= OFS_TAB[pkg_type_r][seg];
      slp_r    <= SLP_TAB[pkg_type_r][seg];
    end
  end

  // ---------------------------------------------------------------------------
  // Multiply stage: offset * broadband and slope * infrared, exact
  // ---------------------------------------------------------------------------
  localparam int MUL_W = CH_W + COEF_W;
  logic [MUL_W-1:0] pos_r, neg_r;

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      pos_r <= MUL_W'(c0_seg_r) * MUL_W'(ofs_r);
      neg_r <= MUL_W'(c1_seg_r) * MUL_W'(slp_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Output stage: clamp at zero, round, shift, saturate to 20 bits
  // ---------------------------------------------------------------------------
  logic [MUL_W-1:0] diff;
  logic [MUL_W:0]   rnd;
  logic [MUL_W-LUX_SH:0] shifted;
  lux_t             lux_nxt, lux_r;

  always_comb begin
    diff    = (pos_r > neg_r) ? (pos_r - neg_r) : '0;
    rnd     = {1'b0, diff} + ((MUL_W + 1)'(1) << (LUX_SH - 1));
    shifted = rnd[MUL_W:LUX_SH];
    if (shifted > (MUL_W - LUX_SH + 1)'({LUX_W{1'b1}})) begin
      lux_nxt = '1;
    end else begin
      lux_nxt = LUX_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) begin
      lux_r <= lux_nxt;
    end
  end

  assign out_ch.valid = vld_r[ST_OUT];
  assign out_ch.lux   = lux_r;

`ifndef NO_ASSERTIONS
  // Input back-pressure only when every stage is occupied
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r))
    else $error("input stalled while pipeline has a free stage");

  // Remainder must end below the divisor on an in-range divide
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_SEG - 1] && !dq.sat && !dq.zero) |-> (dq.rem < REM_W'(dq.c0)))
    else $error("ratio divider remainder out of range");

  // Zero positive term always yields zero lux
  a_zero_lux: assert property (@(posedge clk) disable iff (!rst_n)
    (adv[ST_OUT] && vld_r[ST_MUL] && (pos_r == '0)) |=> (lux_r == '0))
    else $error("nonzero lux from zero offset product");
`endif

endmodule

// ----- verif/two_channel_lux_calculation_core_tb.sv -----
// Self-checking testbench for two_channel_lux_calculation_core: random and directed count pairs
// over every register setting, checked against an in-bench lux predictor.
// Depends on lux_pkg, lux_in_if, lux_out_if and the core itself.
`timescale 1ns / 1ps

module two_channel_lux_calculation_core_tb;
  import lux_pkg::*;

  localparam int IDLE_PCT    = 28;     // chance in 100 that a side idles in a cycle
  localparam int HOLD_CYCLES = 60;     // long receiver stall, well past the pipeline depth
  localparam int DRAIN_WAIT  = 20;     // pipeline holds 11 transactions, leave margin
  localparam int STALL_LIMIT = 2000;   // cycles with no transaction before giving up
  localparam int PHASES      = 16;
  localparam int PHASE_ITEMS = 56;
  localparam int MAX_SHOWN   = 10;

  // Coefficient tables, row 0 = T package, row 1 = CS package
  localparam int unsigned SEG_LIMIT [2][8] = '{
    '{'h040, 'h080, 'h0c0, 'h100, 'h138, 'h19a, 'h29a, 'h29a},
    '{'h043, 'h085, 'h0c8, 'h10a, 'h14d, 'h19a, 'h29a, 'h29a}
  };
  localparam int unsigned SEG_OFFSET [2][8] = '{
    '{'h1f2, 'h214, 'h23f, 'h270, 'h16f, 'h0d2, 'h018, 'h000},
    '{'h204, 'h228, 'h253, 'h282, 'h177, 'h101, 'h037, 'h000}
  };
  localparam int unsigned SEG_SLOPE [2][8] = '{
    '{'h1be, 'h2d1, 'h37b, 'h3fe, 'h1fc, 'h0fb, 'h012, 'h000},
    '{'h1ad, 'h2c1, 'h363, 'h3df, 'h1dd, 'h127, 'h02b, 'h000}
  };

  typedef struct packed {
    count_t bb;
    count_t ir;
  } count_pair_t;

  typedef struct packed {
    count_t bb;
    count_t ir;
    lux_t   lux;
  } lux_check_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [1:0] cfg_wdata;

  lux_in_if  in_ch ();
  lux_out_if out_ch ();

  // Shadow copy of the configuration registers
  logic       gain_hi;
  logic [1:0] integ_sel;
  logic       pkg_cs;

  count_pair_t pair_queue [$];   // pairs waiting to be offered
  lux_check_t  lux_expect [$];   // lux values owed by the core, oldest first

  logic in_taken;      // the offered pair went in at the last rising edge
  logic sender_calm;   // no sender idling
  logic recv_calm;     // no receiver idling
  logic stall_req;     // ask the receiver for one long hold-off
  logic stall_done;
  int   hold_left;
  int   quiet_cycles;
  int   errors;

  two_channel_lux_calculation_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lux for one count pair under the current shadow configuration.
  // All arithmetic is done in 64 bits so no product wraps.
  function automatic lux_t calc_lux(count_t bb, count_t ir);
    logic [63:0] scale;
    logic [63:0] c0;
    logic [63:0] c1;
    logic [63:0] ratio;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] val;
    int          seg;
    int          row;
    row = pkg_cs ? 1 : 0;
    case (integ_sel)
      INTEG_13MS:  scale = 64'h7517;
      INTEG_101MS: scale = 64'h0fe7;
      default:     scale = 64'h0400;   // 402 ms and the reserved code: unit scale
    endcase
    if (!gain_hi) scale = scale << 4;   // 1x gain needs the extra factor of 16
    c0 = (64'(bb) * scale) >> 10;
    c1 = (64'(ir) * scale) >> 10;
    // Ratio with one extra fraction bit, then rounded; zero broadband gives zero
    ratio = (c0 != 0) ? ((c1 << 10) / c0) : 64'd0;
    ratio = (ratio + 1) >> 1;
    // First segment whose limit covers the ratio; past the end, the zero segment
    seg = 7;
    for (int i = 7; i >= 0; i--) begin
      if (ratio <= 64'(SEG_LIMIT[row][i])) seg = i;
    end
    pos = c0 * 64'(SEG_OFFSET[row][seg]);
    neg = c1 * 64'(SEG_SLOPE[row][seg]);
    val = (pos > neg) ? (pos - neg) : 64'd0;   // clamp a negative difference
    val = (val + 64'd8192) >> 14;
    if (val > 64'hfffff) val = 64'hfffff;
    return lux_t'(val);
  endfunction

  // Sender: change the offer only on the falling edge, and only once the
  // current pair is gone or nothing is on offer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pair_queue.size() > 0 &&
          (sender_calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_ch.valid           <= 1'b1;
        in_ch.broadband_count <= pair_queue[0].bb;
        in_ch.infrared_count  <= pair_queue[0].ir;
        void'(pair_queue.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off counted here so the
  // pipeline fills and in_ch.ready drops.
  always @(negedge clk) begin
    if (stall_req && !stall_done) begin
      stall_done   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= recv_calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Accept side: predict on every input transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        lux_expect.push_back('{bb:  in_ch.broadband_count,
                               ir:  in_ch.infrared_count,
                               lux: calc_lux(in_ch.broadband_count, in_ch.infrared_count)});
      end
    end
  end

  // Result side: compare against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (lux_expect.size() == 0) begin
        if (errors < MAX_SHOWN)
          $display("unexpected result: lux=%0d with nothing outstanding", out_ch.lux);
        errors <= errors + 1;
      end else begin
        if (out_ch.lux !== lux_expect[0].lux) begin
          if (errors < MAX_SHOWN)
            $display("lux mismatch: bb=%0d ir=%0d expected=%0d actual=%0d",
                     lux_expect[0].bb, lux_expect[0].ir, lux_expect[0].lux, out_ch.lux);
          errors <= errors + 1;
        end
        void'(lux_expect.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold until the core has nothing in flight and nothing is queued.
  task automatic wait_idle();
    while (pair_queue.size() != 0 || in_ch.valid || lux_expect.size() != 0)
      @(posedge clk);
  endtask

  // One register write on the falling edge; the shadow follows at once since
  // the core is idle whenever this runs.
  task automatic write_reg(logic [1:0] idx, logic [1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_HIGH_GAIN: gain_hi   = val[0];
      REG_INTEG_SEL: integ_sel = val;
      REG_PKG_TYPE:  pkg_cs    = val[0];
      default: ;
    endcase
  endtask

  initial begin
    int unsigned bb;
    int unsigned ir;
    int unsigned r;
    logic [1:0]  integ;
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_HIGH_GAIN;
    cfg_wdata             = 2'd0;
    in_ch.valid           = 1'b0;
    in_ch.broadband_count = '0;
    in_ch.infrared_count  = '0;
    out_ch.ready          = 1'b0;
    in_taken              = 1'b0;
    sender_calm           = 1'b0;
    recv_calm             = 1'b0;
    stall_req             = 1'b0;
    stall_done            = 1'b0;
    hold_left             = 0;
    quiet_cycles          = 0;
    errors                = 0;
    gain_hi               = 1'b0;
    integ_sel             = INTEG_13MS;
    pkg_cs                = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk every combination: package toggles fastest, then integration code
    // (reserved code included), then gain. Phase 0 matches the reset values.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      integ = 2'(ph >> 1);
      write_reg(REG_HIGH_GAIN, {1'b0, ph[3]});
      write_reg(REG_INTEG_SEL, integ);
      write_reg(REG_PKG_TYPE,  {1'b0, ph[0]});
      @(negedge clk);
      cfg_we <= 1'b0;
      @(posedge clk);

      // Phase 5: long receiver hold-off, sender offering every cycle; phase 9: no idling
      sender_calm = (ph == 5) || (ph == 9);
      recv_calm   = (ph == 9);
      if (ph == 5) stall_req = 1'b1;

      if (ph == 0) begin
        // Field extremes and mixed bit patterns
        pair_queue.push_back('{bb: 16'h0000, ir: 16'h0000});
        pair_queue.push_back('{bb: 16'h0000, ir: 16'hffff});   // zero broadband
        pair_queue.push_back('{bb: 16'hffff, ir: 16'h0000});
        pair_queue.push_back('{bb: 16'hffff, ir: 16'hffff});
        pair_queue.push_back('{bb: 16'h0001, ir: 16'h0000});
        pair_queue.push_back('{bb: 16'h0001, ir: 16'h0001});
        pair_queue.push_back('{bb: 16'haaaa, ir: 16'h5555});
        pair_queue.push_back('{bb: 16'h5555, ir: 16'haaaa});
        pair_queue.push_back('{bb: 16'd100,  ir: 16'd200});    // ratio past the last segment
        // With bb = 512 the ratio equals ir, so these sit on and just past breakpoints
        pair_queue.push_back('{bb: 16'd512, ir: 16'h040});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h041});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h080});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h081});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h0c0});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h0c1});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h100});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h101});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h138});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h139});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h19a});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h19b});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h29a});
        pair_queue.push_back('{bb: 16'd512, ir: 16'h29b});
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // Aim at a chosen ratio so every segment and breakpoint gets traffic
            bb = $urandom_range(1, 65535);
            r  = $urandom_range(0, 'h2c0);
            ir = (bb * r) >> 9;
            if (ir > 65535) ir = 65535;
          end
          4, 5, 6: begin
            bb = $urandom_range(0, 65535);
            ir = $urandom_range(0, 65535);
          end
          7: begin
            // Tiny counts: small scaled values and heavy rounding
            bb = $urandom_range(0, 15);
            ir = $urandom_range(0, 15);
          end
          8: begin
            bb = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(0, 65535);
            ir = ($urandom_range(0, 1) != 0) ? 0 : 65535;
          end
          default: begin
            bb = $urandom_range(0, 255);
            ir = $urandom_range(1024, 65535);
          end
        endcase
        pair_queue.push_back('{bb: count_t'(bb), ir: count_t'(ir)});
      end
    end

    // Drain, then let the pipeline settle before judging
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (lux_expect.size() != 0) errors = errors + lux_expect.size();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
